// File: sv/vector3_normalize_unit_macros.svh
// ----------------------------------------------------------------------------
// vector3_normalize_unit_macros
// Assertion macros shared by the vector normalization unit.
// ----------------------------------------------------------------------------
`ifndef VECTOR3_NORMALIZE_UNIT_MACROS_SVH
`define VECTOR3_NORMALIZE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VNU_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vnu implication failed");

// The consequent must hold in the cycle after the antecedent.
`define VNU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vnu next-cycle check failed");

`endif

// File: sv/vnu_pkg.sv
// ----------------------------------------------------------------------------
// vnu_pkg
// Widths, payload types and the pipeline record of the normalization unit.
// ----------------------------------------------------------------------------
`default_nettype none

package vnu_pkg;

  localparam int COMP_W = 16;
  localparam int FRAC_W = 14;
  localparam int SUM_W  = 2 * COMP_W;
  localparam int UNIT_W = FRAC_W + 2;

  typedef struct packed {
    logic signed [COMP_W-1:0] x_in;
    logic signed [COMP_W-1:0] y_in;
    logic signed [COMP_W-1:0] z_in;
  } vnu_in_t;

  typedef struct packed {
    logic signed [UNIT_W-1:0] x_unit;
    logic signed [UNIT_W-1:0] y_unit;
    logic signed [UNIT_W-1:0] z_unit;
    logic [COMP_W-1:0]        length;
    logic                     zero_vector;
  } vnu_out_t;

  typedef struct packed {
    logic [COMP_W-1:0] ax;
    logic [COMP_W-1:0] ay;
    logic [COMP_W-1:0] az;
    logic              nx;
    logic              ny;
    logic              nz;
    logic              zero;
    logic [SUM_W-1:0]  rem;
    logic [COMP_W-1:0] root;
    logic [COMP_W:0]   drx;
    logic [COMP_W:0]   dry;
    logic [COMP_W:0]   drz;
    logic [FRAC_W:0]   qx;
    logic [FRAC_W:0]   qy;
    logic [FRAC_W:0]   qz;
  } vnu_pipe_t;

endpackage

`default_nettype wire

// File: sv/vnu_square.sv
// ----------------------------------------------------------------------------
// vnu_square
// Two front stages: absolute values and squares, then the sum of squares.
// ----------------------------------------------------------------------------
`default_nettype none

module vnu_square
  import vnu_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      up_valid,
  output logic           up_ready,
  input  wire vnu_in_t   up_data,
  output logic           dn_valid,
  input  wire logic      dn_ready,
  output vnu_pipe_t      dn_data
);

  logic              a_v_r;
  logic              b_v_r;
  logic              a_rdy;
  logic              b_rdy;
  logic [COMP_W-1:0] ax_nxt, ay_nxt, az_nxt;
  logic [COMP_W-1:0] ax_r, ay_r, az_r;
  logic              nx_r, ny_r, nz_r;
  logic [SUM_W-1:0]  sqx_r, sqy_r, sqz_r;
  logic [SUM_W-1:0]  sum_nxt;
  vnu_pipe_t         p_nxt;
  vnu_pipe_t         p_r;

  assign b_rdy    = !b_v_r || dn_ready;
  assign a_rdy    = !a_v_r || b_rdy;
  assign up_ready = a_rdy;
  assign dn_valid = b_v_r;
  assign dn_data  = p_r;

  always_comb begin
    ax_nxt = up_data.x_in[COMP_W-1] ? (~up_data.x_in) + 1'b1 : up_data.x_in;
    ay_nxt = up_data.y_in[COMP_W-1] ? (~up_data.y_in) + 1'b1 : up_data.y_in;
    az_nxt = up_data.z_in[COMP_W-1] ? (~up_data.z_in) + 1'b1 : up_data.z_in;
    sum_nxt = sqx_r + sqy_r + sqz_r;
    p_nxt      = '0;
    p_nxt.ax   = ax_r;
    p_nxt.ay   = ay_r;
    p_nxt.az   = az_r;
    p_nxt.nx   = nx_r;
    p_nxt.ny   = ny_r;
    p_nxt.nz   = nz_r;
    p_nxt.zero = (sum_nxt == '0);
    p_nxt.rem  = sum_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      if (a_rdy) begin
        a_v_r <= up_valid;
      end
      if (b_rdy) begin
        b_v_r <= a_v_r;
      end
    end
    if (a_rdy && up_valid) begin
      ax_r  <= ax_nxt;
      ay_r  <= ay_nxt;
      az_r  <= az_nxt;
      nx_r  <= up_data.x_in[COMP_W-1];
      ny_r  <= up_data.y_in[COMP_W-1];
      nz_r  <= up_data.z_in[COMP_W-1];
      sqx_r <= ax_nxt * ax_nxt;
      sqy_r <= ay_nxt * ay_nxt;
      sqz_r <= az_nxt * az_nxt;
    end
    if (b_rdy && a_v_r) begin
      p_r <= p_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/vnu_sqrt_cell.sv
// ----------------------------------------------------------------------------
// vnu_sqrt_cell
// One bit of the restoring square root: settles root bit BIT per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module vnu_sqrt_cell
  import vnu_pkg::*;
#(
  parameter int BIT = 0
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      up_valid,
  output logic           up_ready,
  input  wire vnu_pipe_t up_data,
  output logic           dn_valid,
  input  wire logic      dn_ready,
  output vnu_pipe_t      dn_data
);

  logic             v_r;
  logic [SUM_W:0]   term;
  logic [SUM_W:0]   rem_ext;
  vnu_pipe_t        p_nxt;
  vnu_pipe_t        p_r;

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_data  = p_r;

  always_comb begin
    rem_ext = {1'b0, up_data.rem};
    term = ({{(SUM_W + 1 - COMP_W){1'b0}}, up_data.root} << (BIT + 1))
         | ((SUM_W + 1)'(1) << (2 * BIT));
    p_nxt = up_data;
    if (rem_ext >= term) begin
      p_nxt.rem       = SUM_W'(rem_ext - term);
      p_nxt.root[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
    if (up_ready && up_valid) begin
      p_r <= p_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/vnu_div_cell.sv
// ----------------------------------------------------------------------------
// vnu_div_cell
// One quotient bit of the three restoring dividers by the magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module vnu_div_cell
  import vnu_pkg::*;
#(
  parameter int BIT = 0
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      up_valid,
  output logic           up_ready,
  input  wire vnu_pipe_t up_data,
  output logic           dn_valid,
  input  wire logic      dn_ready,
  output vnu_pipe_t      dn_data
);

  logic            v_r;
  logic [COMP_W:0] len;
  logic [COMP_W:0] rx, ry, rz;
  logic [COMP_W:0] sx, sy, sz;
  vnu_pipe_t       p_nxt;
  vnu_pipe_t       p_r;

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_data  = p_r;

  always_comb begin
    len = {1'b0, up_data.root};
    if (BIT == FRAC_W) begin
      rx = {1'b0, up_data.ax};
      ry = {1'b0, up_data.ay};
      rz = {1'b0, up_data.az};
    end else begin
      rx = up_data.drx;
      ry = up_data.dry;
      rz = up_data.drz;
    end
    p_nxt = up_data;
    sx = rx;
    sy = ry;
    sz = rz;
    if (rx >= len) begin
      sx = rx - len;
      p_nxt.qx[BIT] = 1'b1;
    end
    if (ry >= len) begin
      sy = ry - len;
      p_nxt.qy[BIT] = 1'b1;
    end
    if (rz >= len) begin
      sz = rz - len;
      p_nxt.qz[BIT] = 1'b1;
    end
    p_nxt.drx = sx << 1;
    p_nxt.dry = sy << 1;
    p_nxt.drz = sz << 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
    if (up_ready && up_valid) begin
      p_r <= p_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/vector3_normalize_unit.sv
// ----------------------------------------------------------------------------
// vector3_normalize_unit
// Magnitude and unit vector of a 3D fixed-point vector.
//
//   Channel  Ports                 Contents
//   input    in_valid/in_ready     x_in, y_in, z_in (Q7.8)
//   output   out_valid/out_ready   x/y/z_unit (Q1.14), length, zero_vector
//
// One transaction per cycle is taken and delivered when nothing stalls.
// The pipeline runs through the squaring stages, one square-root cell per root
// bit, one divider cell per quotient bit and the output register.
// Every stage holds its data while the next one is full and stalled.
// Reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

`include "vector3_normalize_unit_macros.svh"

module vector3_normalize_unit
  import vnu_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire vnu_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output vnu_out_t     out_data
);

  localparam int NSQ  = COMP_W;
  localparam int NDIV = FRAC_W + 1;
  localparam logic signed [UNIT_W-1:0] UNIT_ONE = UNIT_W'(1 << FRAC_W);

  logic      sq_v [0:NSQ];
  logic      sq_r [0:NSQ];
  vnu_pipe_t sq_p [0:NSQ];
  logic      dv_v [0:NDIV];
  logic      dv_r [0:NDIV];
  vnu_pipe_t dv_p [0:NDIV];

  logic      out_valid_r;
  vnu_out_t  out_r;
  vnu_out_t  out_nxt;
  vnu_pipe_t last;

  vnu_square u_square (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_data  (in_data),
    .dn_valid (sq_v[0]),
    .dn_ready (sq_r[0]),
    .dn_data  (sq_p[0])
  );

  for (genvar i = 0; i < NSQ; i++) begin : g_sqrt
    vnu_sqrt_cell #(.BIT(NSQ - 1 - i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (sq_v[i]),
      .up_ready (sq_r[i]),
      .up_data  (sq_p[i]),
      .dn_valid (sq_v[i+1]),
      .dn_ready (sq_r[i+1]),
      .dn_data  (sq_p[i+1])
    );
  end

  assign dv_v[0]   = sq_v[NSQ];
  assign dv_p[0]   = sq_p[NSQ];
  assign sq_r[NSQ] = dv_r[0];

  for (genvar j = 0; j < NDIV; j++) begin : g_div
    vnu_div_cell #(.BIT(NDIV - 1 - j)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (dv_v[j]),
      .up_ready (dv_r[j]),
      .up_data  (dv_p[j]),
      .dn_valid (dv_v[j+1]),
      .dn_ready (dv_r[j+1]),
      .dn_data  (dv_p[j+1])
    );
  end

  assign last       = dv_p[NDIV];
  assign dv_r[NDIV] = !out_valid_r || out_ready;
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;

  always_comb begin
    out_nxt        = '0;
    out_nxt.zero_vector = last.zero;
    if (!last.zero) begin
      out_nxt.x_unit = last.nx ? -{1'b0, last.qx} : {1'b0, last.qx};
      out_nxt.y_unit = last.ny ? -{1'b0, last.qy} : {1'b0, last.qy};
      out_nxt.z_unit = last.nz ? -{1'b0, last.qz} : {1'b0, last.qz};
      out_nxt.length = last.root;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dv_r[NDIV]) begin
      out_valid_r <= dv_v[NDIV];
    end
    if (dv_r[NDIV] && dv_v[NDIV]) begin
      out_r <= out_nxt;
    end
  end

  `VNU_ASSERT_IMPLY(a_zero_len, out_valid_r && out_r.zero_vector, out_r.length == '0)
  `VNU_ASSERT_IMPLY(a_nonzero_len, out_valid_r && !out_r.zero_vector, out_r.length != '0)
  `VNU_ASSERT_IMPLY(a_unit_range, out_valid_r, (out_r.x_unit <= UNIT_ONE) && (out_r.x_unit >= -UNIT_ONE))
  `VNU_ASSERT_NEXT(a_hold_out, out_valid_r && !out_ready, out_valid_r && $stable(out_r))

endmodule

`default_nettype wire

// File: bench/vector3_normalize_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_normalize_unit_checker
// Watches both channels of the normalization unit, computes the expected unit
// vector and magnitude of every accepted vector, and compares each delivered
// result with the oldest pending one, field by field.
// ----------------------------------------------------------------------------

module vector3_normalize_unit_checker
  import vnu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  vnu_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  vnu_out_t out_data,
  output int       error_count,
  output int       pending_count,
  output int       result_count,
  output int       zero_count
);

  vnu_out_t expected_norms[$];

  function automatic logic [COMP_W-1:0] magnitude_of(logic [COMP_W-1:0] raw);
    return raw[COMP_W-1] ? COMP_W'(-raw) : raw;
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] n);
    logic [63:0] root;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      if ((root | (64'd1 << b)) * (root | (64'd1 << b)) <= n) begin
        root = root | (64'd1 << b);
      end
    end
    return root;
  endfunction

  function automatic logic [UNIT_W-1:0] unit_part(logic [COMP_W-1:0] raw,
                                                   logic [63:0] len);
    logic [63:0] quot;
    quot = ({48'd0, magnitude_of(raw)} << FRAC_W) / len;
    if (raw[COMP_W-1]) begin
      quot = -quot;
    end
    return quot[UNIT_W-1:0];
  endfunction

  function automatic vnu_out_t normalize(vnu_in_t v);
    vnu_out_t r;
    logic [63:0] ax, ay, az, sum, len;
    ax = magnitude_of(v.x_in);
    ay = magnitude_of(v.y_in);
    az = magnitude_of(v.z_in);
    sum = ax * ax + ay * ay + az * az;
    r = '0;
    if (sum == 0) begin
      r.zero_vector = 1'b1;
    end else begin
      len = root_floor(sum);
      r.x_unit = unit_part(v.x_in, len);
      r.y_unit = unit_part(v.y_in, len);
      r.z_unit = unit_part(v.z_in, len);
      r.length = len[COMP_W-1:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    vnu_out_t exp_norm;
    if (!rst_n) begin
      error_count <= 0;
      result_count <= 0;
      zero_count <= 0;
      pending_count <= 0;
      expected_norms.delete();
    end else begin
      if (in_valid && in_ready) begin
        expected_norms.push_back(normalize(in_data));
      end
      if (out_valid && out_ready) begin
        result_count <= result_count + 1;
        if (expected_norms.size() == 0) begin
          $error("result transaction with nothing expected");
          error_count <= error_count + 1;
        end else begin
          exp_norm = expected_norms.pop_front();
          if (exp_norm.zero_vector) begin
            zero_count <= zero_count + 1;
          end
          if (out_data !== exp_norm) begin
            error_count <= error_count + 1;
            if (out_data.x_unit !== exp_norm.x_unit) begin
              $error("x_unit: expected %0d, actual %0d", exp_norm.x_unit, out_data.x_unit);
            end
            if (out_data.y_unit !== exp_norm.y_unit) begin
              $error("y_unit: expected %0d, actual %0d", exp_norm.y_unit, out_data.y_unit);
            end
            if (out_data.z_unit !== exp_norm.z_unit) begin
              $error("z_unit: expected %0d, actual %0d", exp_norm.z_unit, out_data.z_unit);
            end
            if (out_data.length !== exp_norm.length) begin
              $error("length: expected %0d, actual %0d", exp_norm.length, out_data.length);
            end
            if (out_data.zero_vector !== exp_norm.zero_vector) begin
              $error("zero_vector: expected %0b, actual %0b", exp_norm.zero_vector,
                     out_data.zero_vector);
            end
          end
        end
      end
      pending_count <= expected_norms.size();
    end
  end

endmodule

// File: bench/vector3_normalize_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_normalize_unit_test
// Drives directed and random vectors into the normalization unit under
// varying idle and stall patterns, and gives the verdict from the checker.
// ----------------------------------------------------------------------------

module vector3_normalize_unit_test;
  import vnu_pkg::*;

  localparam int LATENCY = 34;
  localparam int RANDOM_COUNT = 750;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  vnu_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  vnu_out_t out_data;
  int       error_count, pending_count, result_count, zero_count;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  logic     hold_off = 1'b0;

  vector3_normalize_unit u_top (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  vector3_normalize_unit_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data), .error_count(error_count), .pending_count(pending_count),
    .result_count(result_count), .zero_count(zero_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [COMP_W-1:0] random_component();
    case ($urandom_range(5))
      0: return COMP_W'($urandom_range(15)) - COMP_W'(8);
      1: return {1'b1, {(COMP_W-1){1'b0}}};
      2: return {1'b0, {(COMP_W-1){1'b1}}};
      default: return COMP_W'($urandom);
    endcase
  endfunction

  task automatic send_vector(logic [COMP_W-1:0] x, logic [COMP_W-1:0] y,
                             logic [COMP_W-1:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= '{x_in: x, y_in: y, z_in: z};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) begin
      send_vector(random_component(), random_component(), random_component());
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_count != 0) begin
      @(negedge clk);
    end
  endtask

  initial begin
    logic [COMP_W-1:0] max_neg, max_pos;
    max_neg = {1'b1, {(COMP_W-1){1'b0}}};
    max_pos = {1'b0, {(COMP_W-1){1'b1}}};
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_vector('0, '0, '0);
    send_vector(COMP_W'(1), '0, '0);
    send_vector('0, COMP_W'(-1), '0);
    send_vector('0, '0, COMP_W'(256));
    send_vector(max_neg, '0, '0);
    send_vector(max_pos, '0, '0);
    send_vector(max_neg, max_neg, max_neg);
    send_vector(max_pos, max_pos, max_pos);
    send_vector(max_pos, max_neg, max_pos);
    send_vector(COMP_W'(3), COMP_W'(4), '0);
    send_vector(COMP_W'(-3), COMP_W'(-4), COMP_W'(12));
    send_vector(COMP_W'(1), COMP_W'(1), COMP_W'(1));
    send_vector(COMP_W'(-1), COMP_W'(-1), COMP_W'(-1));
    send_vector(16'h5555, 16'haaaa, 16'h00ff);
    send_vector(16'haaaa, 16'h5555, 16'hff00);
    send_vector('0, '0, '0);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_random(RANDOM_COUNT / 5);

    hold_off = 1'b1;
    fork
      begin
        repeat (3 * LATENCY) @(negedge clk);
        hold_off = 1'b0;
      end
      send_random(2 * LATENCY);
    join
    drain_results();

    send_idle_pct = 80;
    send_random(RANDOM_COUNT / 5);
    send_idle_pct = 0;
    recv_stall_pct = 80;
    send_random(RANDOM_COUNT / 5);
    drain_results();
    send_idle_pct = 36;
    recv_stall_pct = 36;
    send_random(RANDOM_COUNT / 5);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_random(RANDOM_COUNT - 4 * (RANDOM_COUNT / 5) - 2 * LATENCY);

    drain_results();
    repeat (2 * LATENCY) @(negedge clk);
    $display("Covered %0d results, %0d of them zero vectors, under several idle mixes.",
             result_count, zero_count);
    if (error_count == 0) begin
      $display("vector3_normalize_unit: match");
    end else begin
      $display("vector3_normalize_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("vector3_normalize_unit: mismatch");
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/vnu_pkg.sv
sv/vnu_square.sv
sv/vnu_sqrt_cell.sv
sv/vnu_div_cell.sv
sv/vector3_normalize_unit.sv
bench/vector3_normalize_unit_checker.sv
bench/vector3_normalize_unit_test.sv
